// ===== rtl/rpfa_pkg.sv =====
package rpfa_pkg;

  // Default sizing of the count store
  localparam int PAGES_DEF      = 4096;
  localparam int COUNT_BITS_DEF = 8;

  // Fixed field widths of the channels
  localparam int FUNC_W    = 2;
  localparam int PAGE_W    = 12;
  localparam int STATUS_W  = 3;
  localparam int CNT_OUT_W = 8;
  localparam int FREE_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [CNT_OUT_W-1:0] cnt_out_t;
  typedef logic [FREE_W-1:0]    free_t;
  typedef logic [FREE_W-1:0]    pcount_t;

  // Register reset values
  localparam page_t   FIRST_USABLE_RESET = page_t'(256);
  localparam pcount_t PAGE_COUNT_RESET   = pcount_t'(4096);

  // Request kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_SHARE   = 2'd2,
    FUNC_PROBE   = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_MEM    = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NOT_ALLOC = 3'd3,
    ST_SATURATED = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_USABLE = 2'd0,
    REG_PAGE_COUNT   = 2'd1
  } reg_idx_t;

  // Configuration state handed to the controller
  typedef struct packed {
    logic    wr;
    page_t   first_usable;
    pcount_t page_count;
  } cfg_state_t;

endpackage

// ===== rtl/rpfa_if.sv =====
// Request channel
interface rpfa_req_if;
  logic                          valid;
  logic                          ready;
  logic [rpfa_pkg::FUNC_W-1:0]   func;
  logic [rpfa_pkg::PAGE_W-1:0]   page_index;

  modport source (output valid, output func, output page_index, input ready);
  modport sink   (input valid, input func, input page_index, output ready);
endinterface

// Result channel
interface rpfa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [rpfa_pkg::PAGE_W-1:0]    granted_page;
  logic [rpfa_pkg::STATUS_W-1:0]  status;
  logic [rpfa_pkg::CNT_OUT_W-1:0] count_after;
  logic [rpfa_pkg::FREE_W-1:0]    free_frames;

  modport source (output valid, output granted_page, output status, output count_after,
                  output free_frames, input ready);
  modport sink   (input valid, input granted_page, input status, input count_after,
                  input free_frames, output ready);
endinterface

// Configuration write channel
interface rpfa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rpfa_pkg::CFG_IDX_W-1:0] index;
  logic [rpfa_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rpfa_count_ram.sv =====
// Reference count store: one write port, one read port, registered read data
module rpfa_count_ram #(
  parameter int DEPTH = rpfa_pkg::PAGES_DEF,
  parameter int WIDTH = rpfa_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rpfa_ctrl.sv =====
// Sequencer: clear pass, free-page recount, first-fit scan and read-modify-write
module rpfa_ctrl #(
  parameter int PAGES      = rpfa_pkg::PAGES_DEF,
  parameter int COUNT_BITS = rpfa_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rpfa_pkg::cfg_state_t       cfg,
  rpfa_req_if.sink                   req,
  rpfa_rsp_if.source                 rsp,
  output logic                       mem_we,
  output logic [$clog2(PAGES)-1:0]   mem_waddr,
  output logic [COUNT_BITS-1:0]      mem_wdata,
  output logic                       mem_re,
  output logic [$clog2(PAGES)-1:0]   mem_raddr,
  input  logic [COUNT_BITS-1:0]      mem_rdata
);

  localparam int AW = $clog2(PAGES);
  localparam int CW = (AW + 1 > rpfa_pkg::FREE_W) ? AW + 1 : rpfa_pkg::FREE_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [CW-1:0]         PAGES_W   = CW'(PAGES);
  localparam logic [CW-1:0]         LAST_PAGE = CW'(PAGES - 1);

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_RECOUNT = 6'b000010,
    S_IDLE    = 6'b000100,
    S_READ    = 6'b001000,
    S_SCAN    = 6'b010000,
    S_FINISH  = 6'b100000
  } state_t;

  state_t                 state;
  logic                   dirty;
  logic [CW-1:0]          scan_addr;
  logic [CW-1:0]          rd_addr;
  logic                   pend;
  logic [AW:0]            zero_cnt;
  logic [AW:0]            free_cnt;
  rpfa_pkg::func_t        req_func;
  rpfa_pkg::page_t        req_idx;
  rpfa_pkg::page_t        res_granted;
  rpfa_pkg::status_t      res_status;
  rpfa_pkg::cnt_out_t     res_after;
  logic                   rsp_valid;
  rpfa_pkg::page_t        out_granted;
  rpfa_pkg::status_t      out_status;
  rpfa_pkg::cnt_out_t     out_after;
  rpfa_pkg::free_t        out_free;

  logic [CW-1:0]          first_ext;
  logic [CW-1:0]          pcount_ext;
  logic [CW-1:0]          range_end;
  logic [CW-1:0]          idx_ext;
  logic                   in_usable;
  logic                   in_ready;
  logic                   in_fire;
  logic                   scan_more;
  logic                   rd_zero;
  logic                   hit;
  logic [COUNT_BITS-1:0]  cnt_dec;
  logic [COUNT_BITS-1:0]  cnt_inc;

  // Usable range [first_usable, min(page_count, PAGES))
  assign first_ext  = CW'(cfg.first_usable);
  assign pcount_ext = CW'(cfg.page_count);
  assign range_end  = (pcount_ext < PAGES_W) ? pcount_ext : PAGES_W;
  assign idx_ext    = CW'(req.page_index);
  assign in_usable  = (idx_ext >= first_ext) && (idx_ext < range_end);

  assign in_ready   = (state == S_IDLE) && !dirty;
  assign in_fire    = req.valid && in_ready;
  assign scan_more  = scan_addr < range_end;
  assign rd_zero    = (mem_rdata == '0);
  assign hit        = pend && rd_zero;
  assign cnt_dec    = mem_rdata - 1'b1;
  assign cnt_inc    = mem_rdata + 1'b1;

  assign req.ready        = in_ready;
  assign rsp.valid        = rsp_valid;
  assign rsp.granted_page = out_granted;
  assign rsp.status       = out_status;
  assign rsp.count_after  = out_after;
  assign rsp.free_frames  = out_free;

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_addr[AW-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = scan_addr[AW-1:0];
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_RECOUNT: begin
        mem_re = !dirty && scan_more;
      end
      S_IDLE: begin
        mem_raddr = idx_ext[AW-1:0];
        mem_re    = in_fire && (rpfa_pkg::func_t'(req.func) != rpfa_pkg::FUNC_ALLOC)
                    && in_usable;
      end
      S_READ: begin
        mem_waddr = rd_addr[AW-1:0];
        if (!rd_zero) begin
          if (req_func == rpfa_pkg::FUNC_RELEASE) begin
            mem_we    = 1'b1;
            mem_wdata = cnt_dec;
          end else if (req_func == rpfa_pkg::FUNC_SHARE && mem_rdata != COUNT_MAX) begin
            mem_we    = 1'b1;
            mem_wdata = cnt_inc;
          end
        end
      end
      S_SCAN: begin
        mem_waddr = rd_addr[AW-1:0];
        if (hit) begin
          mem_we    = 1'b1;
          mem_wdata = COUNT_BITS'(1);
        end else begin
          mem_re = scan_more;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      dirty     <= 1'b1;
      scan_addr <= '0;
      pend      <= 1'b0;
      zero_cnt  <= '0;
      free_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        // Zero every entry once after reset
        S_CLEAR: begin
          scan_addr <= scan_addr + 1'b1;
          if (scan_addr == LAST_PAGE) begin
            state <= S_RECOUNT;
          end
        end
        // Count zero entries over the usable range; restart on a register write
        S_RECOUNT: begin
          if (dirty) begin
            dirty     <= 1'b0;
            scan_addr <= first_ext;
            pend      <= 1'b0;
            zero_cnt  <= '0;
          end else begin
            pend    <= scan_more;
            rd_addr <= scan_addr;
            if (scan_more) begin
              scan_addr <= scan_addr + 1'b1;
            end
            if (hit) begin
              zero_cnt <= zero_cnt + 1'b1;
            end
            if (!scan_more && !pend) begin
              free_cnt <= zero_cnt;
              state    <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (dirty) begin
            state <= S_RECOUNT;
          end else if (in_fire) begin
            req_func <= rpfa_pkg::func_t'(req.func);
            req_idx  <= req.page_index;
            rd_addr  <= idx_ext;
            if (rpfa_pkg::func_t'(req.func) == rpfa_pkg::FUNC_ALLOC) begin
              scan_addr <= first_ext;
              pend      <= 1'b0;
              state     <= S_SCAN;
            end else if (!in_usable) begin
              res_granted <= req.page_index;
              res_status  <= rpfa_pkg::ST_RANGE;
              res_after   <= '0;
              state       <= S_FINISH;
            end else begin
              state <= S_READ;
            end
          end
        end
        // Count of the requested page is on mem_rdata
        S_READ: begin
          res_granted <= req_idx;
          res_status  <= rpfa_pkg::ST_OK;
          state       <= S_FINISH;
          if (req_func == rpfa_pkg::FUNC_PROBE) begin
            res_after <= rpfa_pkg::cnt_out_t'(mem_rdata);
          end else if (rd_zero) begin
            res_status <= rpfa_pkg::ST_NOT_ALLOC;
            res_after  <= '0;
          end else if (req_func == rpfa_pkg::FUNC_RELEASE) begin
            res_after <= rpfa_pkg::cnt_out_t'(cnt_dec);
            if (cnt_dec == '0) begin
              free_cnt <= free_cnt + 1'b1;
            end
          end else if (mem_rdata == COUNT_MAX) begin
            res_status <= rpfa_pkg::ST_SATURATED;
            res_after  <= rpfa_pkg::cnt_out_t'(mem_rdata);
          end else begin
            res_after <= rpfa_pkg::cnt_out_t'(cnt_inc);
          end
        end
        // First-fit search, one entry per cycle
        S_SCAN: begin
          if (hit) begin
            res_granted <= rpfa_pkg::page_t'(rd_addr);
            res_status  <= rpfa_pkg::ST_OK;
            res_after   <= rpfa_pkg::cnt_out_t'(1);
            free_cnt    <= free_cnt - 1'b1;
            state       <= S_FINISH;
          end else begin
            pend    <= scan_more;
            rd_addr <= scan_addr;
            if (scan_more) begin
              scan_addr <= scan_addr + 1'b1;
            end
            if (!scan_more && !pend) begin
              res_granted <= '0;
              res_status  <= rpfa_pkg::ST_NO_MEM;
              res_after   <= '0;
              state       <= S_FINISH;
            end
          end
        end
        // Hand the result to the output register once it is free
        S_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid   <= 1'b1;
            out_granted <= res_granted;
            out_status  <= res_status;
            out_after   <= res_after;
            out_free    <= rpfa_pkg::free_t'(free_cnt);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
      if (cfg.wr) begin
        dirty <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_read_issued: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> $past(mem_re))
    else $error("read state entered without a count read");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_READ || state == S_SCAN))
    else $error("count write outside clear or update");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= PAGES)
    else $error("free page count above store depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_finish_no_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && !rsp_valid) |=> (state == S_IDLE && rsp_valid))
    else $error("result held back with empty output register");
`endif

endmodule

// ===== rtl/refcount_page_frame_allocator_core.sv =====
// Channel | Modport | Payload
// --------+---------+------------------------------------------------------
// req     | sink    | func, page_index
// rsp     | source  | granted_page, status, count_after, free_frames
// cfg     | sink    | index, data (always ready)
//
// Reset: a clearing pass over all PAGES entries, then a free-page count over the
// usable range, also rerun after each register write.
// Release, share, probe: the count is read (and updated for release and share),
// then the result passes through the finish state (directly when out of range).
// Allocate: first-fit scan at one read per cycle. One request in flight; a
// waiting result stalls only the final step and holds off the next request.
module refcount_page_frame_allocator_core #(
  parameter int PAGES      = rpfa_pkg::PAGES_DEF,
  parameter int COUNT_BITS = rpfa_pkg::COUNT_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  rpfa_req_if.sink   req,
  rpfa_rsp_if.source rsp,
  rpfa_cfg_if.sink   cfg
);

  localparam int AW = $clog2(PAGES);

  rpfa_pkg::page_t      first_usable;
  rpfa_pkg::pcount_t    page_count;
  rpfa_pkg::cfg_state_t cfg_state;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [COUNT_BITS-1:0] mem_rdata;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_usable <= rpfa_pkg::FIRST_USABLE_RESET;
      page_count   <= rpfa_pkg::PAGE_COUNT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        rpfa_pkg::REG_FIRST_USABLE: first_usable <= cfg.data[rpfa_pkg::PAGE_W-1:0];
        rpfa_pkg::REG_PAGE_COUNT:   page_count   <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_state.wr           = cfg.valid;
  assign cfg_state.first_usable = first_usable;
  assign cfg_state.page_count   = page_count;

  rpfa_ctrl #(
    .PAGES      (PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_state),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rpfa_count_ram #(
    .DEPTH (PAGES),
    .WIDTH (COUNT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
